// File: src/prq_pkg.sv
// shared types and constants for the priority ordered ready queue
// no dependencies; imported by every module of the block but prq_ram
`default_nettype none

package prq_pkg;

  // default sizing, used as the defaults of the top level parameters
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int ID_BITS_DEF      = 8;
  localparam int LOWEST_LEVEL_DEF = 3;

  // fixed port widths of the request and result fields
  localparam int ID_W   = 8;
  localparam int PRIO_W = 2;

  // request opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_WALK,
    ST_INS_FIRST,
    ST_POP_HEAD,
    ST_POP_SHIFT,
    ST_REPORT
  } state_t;

  // walk pointer update
  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_TAIL,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  // slot memory write selection
  typedef enum logic [2:0] {
    WR_NONE,
    WR_SHIFT_UP,
    WR_NEW_ABOVE,
    WR_NEW_ZERO,
    WR_SHIFT_DN
  } wr_op_t;

  // entry counter update
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    set_ovf;
    logic    take_head;
    ptr_op_t ptr_op;
    wr_op_t  wr_op;
    cnt_op_t cnt_op;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic new_before;
    logic ptr_zero;
    logic ptr_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: src/prq_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/prq_datapath.sv
// datapath: sorted slot memory, entry counter, walk pointer, result registers
// depends on prq_pkg and prq_ram
`default_nettype none

module prq_datapath import prq_pkg::*; #(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int ID_BITS      = ID_BITS_DEF,
  parameter int LOWEST_LEVEL = LOWEST_LEVEL_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire ctrl_cmd_t                          cmd,
  output dp_status_t                              status,
  input  wire logic [PRIO_W-1:0]                  priority_req,
  input  wire logic [ID_W-1:0]                    proc_id,
  output logic                                    popped_valid,
  output logic      [ID_W-1:0]                    popped_id,
  output logic      [PRIO_W-1:0]                  popped_priority,
  output logic                                    overflow,
  output logic                                    queue_empty,
  output logic      [$clog2(QUEUE_DEPTH+1)-1:0]   occupancy
);

  localparam int AW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int PW  = $clog2(LOWEST_LEVEL + 1);
  localparam int IW  = ID_BITS;
  localparam int EW  = PW + IW;
  localparam int IWX = (IW > ID_W) ? IW : ID_W;
  localparam int PWX = (PW > PRIO_W) ? PW : PRIO_W;

  logic [CW-1:0]  cnt;
  logic [CW-1:0]  cnt_m1;
  logic [AW-1:0]  ptr;
  logic [AW-1:0]  ptr_next;
  logic [PW-1:0]  new_prio;
  logic [IW-1:0]  new_id;
  logic [PW-1:0]  pop_prio;
  logic [IW-1:0]  pop_id;
  logic           pop_valid;
  logic           ovf;

  logic [PWX-1:0] prio_x;
  logic [PWX-1:0] prio_clamp;
  logic [IWX-1:0] id_in_x;
  logic [IWX-1:0] id_out_x;
  logic [PWX-1:0] prio_out_x;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [EW-1:0]  wdata;
  logic [EW-1:0]  rdata;
  logic [PW-1:0]  r_prio;
  logic [IW-1:0]  r_id;

  assign cnt_m1 = cnt - CW'(1);
  assign r_prio = rdata[EW-1:IW];
  assign r_id   = rdata[IW-1:0];

  // clamp requested level into 1..LOWEST_LEVEL, keep low id bits
  always_comb begin
    prio_x = PWX'(priority_req);
    if (prio_x == '0) begin
      prio_clamp = PWX'(1);
    end else if (prio_x > PWX'(LOWEST_LEVEL)) begin
      prio_clamp = PWX'(LOWEST_LEVEL);
    end else begin
      prio_clamp = prio_x;
    end
  end

  assign id_in_x = IWX'(proc_id);

  // request and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      new_prio  <= prio_clamp[PW-1:0];
      new_id    <= id_in_x[IW-1:0];
      ovf       <= cmd.set_ovf;
      pop_valid <= 1'b0;
      pop_prio  <= '0;
      pop_id    <= '0;
    end else if (cmd.take_head) begin
      pop_valid <= 1'b1;
      pop_prio  <= r_prio;
      pop_id    <= r_id;
    end
  end

  // walk pointer; the memory read address follows it so rdata is slot[ptr]
  always_comb begin
    case (cmd.ptr_op)
      PTR_TAIL: ptr_next = cnt_m1[AW-1:0];
      PTR_ZERO: ptr_next = '0;
      PTR_INC:  ptr_next = ptr + AW'(1);
      PTR_DEC:  ptr_next = ptr - AW'(1);
      default:  ptr_next = ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else begin
      ptr <= ptr_next;
    end
  end

  // entry counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (cmd.cnt_op)
        CNT_INC: cnt <= cnt + CW'(1);
        CNT_DEC: cnt <= cnt_m1;
        default: cnt <= cnt;
      endcase
    end
  end

  // slot memory write selection
  always_comb begin
    we    = 1'b1;
    waddr = ptr;
    wdata = rdata;
    case (cmd.wr_op)
      WR_SHIFT_UP: begin
        waddr = ptr + AW'(1);
        wdata = rdata;
      end
      WR_NEW_ABOVE: begin
        waddr = ptr + AW'(1);
        wdata = {new_prio, new_id};
      end
      WR_NEW_ZERO: begin
        waddr = '0;
        wdata = {new_prio, new_id};
      end
      WR_SHIFT_DN: begin
        waddr = ptr - AW'(1);
        wdata = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  prq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(ptr_next),
    .rdata(rdata)
  );

  // status back to the controller
  always_comb begin
    status.full       = (cnt == CW'(QUEUE_DEPTH));
    status.empty      = (cnt == '0);
    status.new_before = (new_prio < r_prio) || ((new_prio == r_prio) && (new_id < r_id));
    status.ptr_zero   = (ptr == '0);
    status.ptr_last   = (ptr == cnt_m1[AW-1:0]);
  end

  // result fields at their port widths
  assign id_out_x        = IWX'(pop_id);
  assign prio_out_x      = PWX'(pop_prio);
  assign popped_valid    = pop_valid;
  assign popped_id       = id_out_x[ID_W-1:0];
  assign popped_priority = prio_out_x[PRIO_W-1:0];
  assign overflow        = ovf;
  assign queue_empty     = (cnt == '0);
  assign occupancy       = cnt;

endmodule

`default_nettype wire

// File: src/prq_ctrl.sv
// controller: sequences insert walks and pop shifts over the slot memory
// depends on prq_pkg
`default_nettype none

module prq_ctrl import prq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       opcode,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd,
  output logic            busy,
  output logic            done
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd.load      = 1'b0;
    cmd.set_ovf   = 1'b0;
    cmd.take_head = 1'b0;
    cmd.ptr_op    = PTR_HOLD;
    cmd.wr_op     = WR_NONE;
    cmd.cnt_op    = CNT_HOLD;
    busy          = 1'b1;
    done          = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (opcode == OP_INSERT) begin
            if (status.full) begin
              cmd.set_ovf = 1'b1;
              state_next  = ST_REPORT;
            end else if (status.empty) begin
              state_next = ST_INS_FIRST;
            end else begin
              cmd.ptr_op = PTR_TAIL;
              state_next = ST_INS_WALK;
            end
          end else begin
            if (status.empty) begin
              state_next = ST_REPORT;
            end else begin
              cmd.ptr_op = PTR_ZERO;
              state_next = ST_POP_HEAD;
            end
          end
        end
      end
      // walk from the tail, moving up every entry with a strictly greater key
      ST_INS_WALK: begin
        if (status.new_before) begin
          cmd.wr_op = WR_SHIFT_UP;
          if (status.ptr_zero) begin
            state_next = ST_INS_FIRST;
          end else begin
            cmd.ptr_op = PTR_DEC;
          end
        end else begin
          cmd.wr_op  = WR_NEW_ABOVE;
          cmd.cnt_op = CNT_INC;
          state_next = ST_REPORT;
        end
      end
      // new entry becomes the head
      ST_INS_FIRST: begin
        cmd.wr_op  = WR_NEW_ZERO;
        cmd.cnt_op = CNT_INC;
        state_next = ST_REPORT;
      end
      // head entry arrives from memory
      ST_POP_HEAD: begin
        cmd.take_head = 1'b1;
        if (status.ptr_last) begin
          cmd.cnt_op = CNT_DEC;
          state_next = ST_REPORT;
        end else begin
          cmd.ptr_op = PTR_INC;
          state_next = ST_POP_SHIFT;
        end
      end
      // move remaining entries down by one slot
      ST_POP_SHIFT: begin
        cmd.wr_op = WR_SHIFT_DN;
        if (status.ptr_last) begin
          cmd.cnt_op = CNT_DEC;
          state_next = ST_REPORT;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end
      ST_REPORT: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/priority_ordered_ready_queue.sv
// priority ordered ready queue: one request in, one result strobed by done.
// an insert on an empty queue writes the head at once, and one on a full queue is dropped;
// else its time grows with the walk from the tail over the single read port, up to n entries.
// a pop's time is set by the shift of the remaining entries; a pop on an empty queue just reports.
// done marks the last busy cycle, so a result comes in the cycle before the next request can.
// the result fields hold until the next request is taken; synchronous reset empties the queue.
`default_nettype none

module priority_ordered_ready_queue import prq_pkg::*; #(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int ID_BITS      = ID_BITS_DEF,
  parameter int LOWEST_LEVEL = LOWEST_LEVEL_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             opcode,
  input  wire logic [PRIO_W-1:0]                priority_req,
  input  wire logic [ID_W-1:0]                  proc_id,
  output logic                                  done,
  output logic                                  popped_valid,
  output logic      [ID_W-1:0]                  popped_id,
  output logic      [PRIO_W-1:0]                popped_priority,
  output logic                                  overflow,
  output logic                                  queue_empty,
  output logic      [$clog2(QUEUE_DEPTH+1)-1:0] occupancy
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  prq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .opcode(opcode),
    .status(status),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  prq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .LOWEST_LEVEL(LOWEST_LEVEL)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .priority_req   (priority_req),
    .proc_id        (proc_id),
    .popped_valid   (popped_valid),
    .popped_id      (popped_id),
    .popped_priority(popped_priority),
    .overflow       (overflow),
    .queue_empty    (queue_empty),
    .occupancy      (occupancy)
  );

  // a dropped insert only happens on a full queue
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    done && overflow |-> occupancy == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("overflow reported while queue not full");

  // a result never both returns an entry and flags a dropped insert
  a_pop_no_ovf: assert property (@(posedge clk) disable iff (rst)
    done && popped_valid |-> !overflow)
    else $error("pop result carries overflow");

  // occupancy never exceeds the queue depth
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("occupancy beyond depth");

  // an accepted request keeps the block busy until its result
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request not held busy");

endmodule

`default_nettype wire

// File: verif/priority_ordered_ready_queue_tb.sv
`timescale 1ns / 100ps
// self-checking bench for the priority ordered ready queue: a directed table, then random
// insert and pop traffic checked against a sorted-queue predictor; needs prq_pkg and the dut

module priority_ordered_ready_queue_tb;
  import prq_pkg::*;

  localparam int DEPTH         = QUEUE_DEPTH_DEF;
  localparam int OCC_W         = $clog2(DEPTH + 1);
  localparam int RANDOM_REQS   = 1130;
  localparam int CALM_TAIL     = 150;
  localparam int STALL_LIMIT   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [ID_W-1:0] ID_MASK = ID_W'((1 << ID_BITS_DEF) - 1);

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic              ovf;
    logic              empty;
    logic [OCC_W-1:0]  occ;
  } outcome_t;

  typedef struct packed {
    logic              op;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
    logic              typed;
    outcome_t          want;
  } directed_row_t;

  typedef enum logic [1:0] {
    MIX_PHASE,
    FILL_PHASE,
    DRAIN_PHASE
  } traffic_mode_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic              opcode;
  logic [PRIO_W-1:0] priority_req;
  logic [ID_W-1:0]   proc_id;
  logic              done;
  logic              popped_valid;
  logic [ID_W-1:0]   popped_id;
  logic [PRIO_W-1:0] popped_priority;
  logic              overflow;
  logic              queue_empty;
  logic [OCC_W-1:0]  occupancy;

  // predictor copy of the sorted slots
  logic [PRIO_W-1:0] held_prio [DEPTH];
  logic [ID_W-1:0]   held_id [DEPTH];
  int                held_count = 0;

  outcome_t      pending_results [$];
  directed_row_t directed [$];

  int error_count  = 0;
  int idle_cycles  = 0;
  int n_requests   = 0;
  int n_inserts    = 0;
  int n_pops       = 0;
  int n_overflows  = 0;
  int n_empty_pops = 0;
  int peak_occ     = 0;

  priority_ordered_ready_queue dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .priority_req    (priority_req),
    .proc_id         (proc_id),
    .done            (done),
    .popped_valid    (popped_valid),
    .popped_id       (popped_id),
    .popped_priority (popped_priority),
    .overflow        (overflow),
    .queue_empty     (queue_empty),
    .occupancy       (occupancy)
  );

  always #1 clk = ~clk;

  // sorted insert before the first strictly greater key, pop from the head
  function automatic outcome_t predict_outcome(logic op, logic [PRIO_W-1:0] prio_in,
                                               logic [ID_W-1:0] id_in);
    outcome_t          r;
    logic [PRIO_W-1:0] lvl;
    logic [ID_W-1:0]   key_id;
    int                pos;
    r = '0;
    if (op == OP_INSERT) begin
      n_inserts++;
      lvl = prio_in;
      if (lvl < 1) lvl = PRIO_W'(1);
      if (lvl > LOWEST_LEVEL_DEF) lvl = PRIO_W'(LOWEST_LEVEL_DEF);
      key_id = id_in & ID_MASK;
      if (held_count >= DEPTH) begin
        r.ovf = 1'b1;
        n_overflows++;
      end else begin
        pos = held_count;
        for (int k = 0; k < held_count; k++) begin
          if (pos == held_count && (lvl < held_prio[k] ||
              (lvl == held_prio[k] && key_id < held_id[k]))) pos = k;
        end
        for (int k = held_count; k > pos; k--) begin
          held_prio[k] = held_prio[k-1];
          held_id[k]   = held_id[k-1];
        end
        held_prio[pos] = lvl;
        held_id[pos]   = key_id;
        held_count++;
      end
    end else begin
      n_pops++;
      if (held_count > 0) begin
        r.valid = 1'b1;
        r.id    = held_id[0];
        r.prio  = held_prio[0];
        for (int k = 1; k < held_count; k++) begin
          held_prio[k-1] = held_prio[k];
          held_id[k-1]   = held_id[k];
        end
        held_count--;
      end else begin
        n_empty_pops++;
      end
    end
    if (held_count > peak_occ) peak_occ = held_count;
    r.empty = (held_count == 0);
    r.occ   = OCC_W'(held_count);
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic add_row(logic op, int prio_in, int id_in, logic typed, logic v, int pid,
                         int ppr, logic ovf, logic emp, int occ);
    directed_row_t row;
    row.op         = op;
    row.prio       = PRIO_W'(prio_in);
    row.id         = ID_W'(id_in);
    row.typed      = typed;
    row.want.valid = v;
    row.want.id    = ID_W'(pid);
    row.want.prio  = PRIO_W'(ppr);
    row.want.ovf   = ovf;
    row.want.empty = emp;
    row.want.occ   = OCC_W'(occ);
    directed.push_back(row);
  endtask

  // present one request and hold it until the block takes it; returns on the accepting edge
  task automatic send_request(logic op, logic [PRIO_W-1:0] prio_in, logic [ID_W-1:0] id_in,
                              logic typed, outcome_t want);
    outcome_t predicted;
    start        <= 1'b1;
    opcode       <= op;
    priority_req <= prio_in;
    proc_id      <= id_in;
    @(posedge clk);
    while (!(start && !busy)) @(posedge clk);
    predicted = predict_outcome(op, prio_in, id_in);
    pending_results.push_back(typed ? want : predicted);
    n_requests++;
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checker, one strobe per request
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual id %0d prio %0d occ %0d",
                 $time, popped_id, popped_priority, occupancy);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("popped_valid", want.valid, popped_valid);
        check_field("popped_id", want.id, popped_id);
        check_field("popped_priority", want.prio, popped_priority);
        check_field("overflow", want.ovf, overflow);
        check_field("queue_empty", want.empty, queue_empty);
        check_field("occupancy", want.occ, occupancy);
      end
    end
  end

  // watchdog on cycles where neither a request nor a result moves
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: nothing moved for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_results.size());
      $display("** priority_ordered_ready_queue: FAILED **");
      $finish;
    end
  end

  initial begin
    int            seg_left;
    logic          gappy;
    traffic_mode_t mode;
    int            insert_pct;
    logic          op;
    logic [ID_W-1:0] id;
    directed_row_t row;

    rst          = 1'b1;
    start        = 1'b0;
    opcode       = OP_INSERT;
    priority_req = '0;
    proc_id      = '0;
    seg_left     = 0;
    gappy        = 1'b0;
    mode         = MIX_PHASE;

    // directed table: op, prio, id, typed, then valid, id, prio, overflow, empty, occupancy
    add_row(OP_POP,    0,   0, 1'b1, 1'b0,   0, 0, 1'b0, 1'b1, 0);  // pop right after reset
    add_row(OP_INSERT, 0,   0, 1'b1, 1'b0,   0, 0, 1'b0, 1'b0, 1);  // level 0 stored as 1
    add_row(OP_INSERT, 3, 255, 1'b1, 1'b0,   0, 0, 1'b0, 1'b0, 2);
    add_row(OP_INSERT, 2, 128, 1'b1, 1'b0,   0, 0, 1'b0, 1'b0, 3);
    add_row(OP_INSERT, 1,   0, 1'b1, 1'b0,   0, 0, 1'b0, 1'b0, 4);  // equal key, goes behind
    add_row(OP_INSERT, 1,   5, 1'b0, 1'b0,   0, 0, 1'b0, 1'b0, 0);
    add_row(OP_INSERT, 2, 127, 1'b0, 1'b0,   0, 0, 1'b0, 1'b0, 0);
    add_row(OP_POP,    0,   0, 1'b1, 1'b1,   0, 1, 1'b0, 1'b0, 5);
    add_row(OP_POP,    3, 255, 1'b1, 1'b1,   0, 1, 1'b0, 1'b0, 4);  // pop ignores payload
    add_row(OP_POP,    0,   0, 1'b1, 1'b1,   5, 1, 1'b0, 1'b0, 3);
    add_row(OP_POP,    0,   0, 1'b1, 1'b1, 127, 2, 1'b0, 1'b0, 2);
    add_row(OP_POP,    0,   0, 1'b1, 1'b1, 128, 2, 1'b0, 1'b0, 1);
    add_row(OP_POP,    0,   0, 1'b1, 1'b1, 255, 3, 1'b0, 1'b1, 0);
    add_row(OP_POP,    0,   0, 1'b1, 1'b0,   0, 0, 1'b0, 1'b1, 0);  // drained queue
    add_row(OP_INSERT, 3,   0, 1'b0, 1'b0,   0, 0, 1'b0, 1'b0, 0);
    add_row(OP_INSERT, 1, 255, 1'b0, 1'b0,   0, 0, 1'b0, 1'b0, 0);
    add_row(OP_INSERT, 2, 170, 1'b0, 1'b0,   0, 0, 1'b0, 1'b0, 0);
    add_row(OP_INSERT, 2,  85, 1'b0, 1'b0,   0, 0, 1'b0, 1'b0, 0);
    add_row(OP_POP,    1,   0, 1'b0, 1'b0,   0, 0, 1'b0, 1'b0, 0);
    add_row(OP_POP,    0,   0, 1'b0, 1'b0,   0, 0, 1'b0, 1'b0, 0);

    // reset
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part
    for (int i = 0; i < directed.size(); i++) begin
      row = directed[i];
      send_request(row.op, row.prio, row.id, row.typed, row.want);
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 14));
    end
    wait_drained();

    // random part: fill, drain and mixed phases so full and empty are both hit often
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        mode     = traffic_mode_t'($urandom_range(0, 2));
        gappy    = $urandom_range(0, 2) != 0;
      end
      seg_left--;
      case (mode)
        FILL_PHASE:  insert_pct = 85;
        DRAIN_PHASE: insert_pct = 15;
        default:     insert_pct = 50;
      endcase
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
      // narrow id pools make equal keys common
      case ($urandom_range(0, 3))
        0:       id = ID_W'($urandom_range(0, 3));
        1:       id = ID_W'($urandom_range(252, 255));
        default: id = ID_W'($urandom);
      endcase
      send_request(op, PRIO_W'($urandom_range(0, 3)), id, 1'b0, '0);
      if (n < RANDOM_REQS - CALM_TAIL) begin
        if (n % 350 == 349) begin
          wait_drained();
        end else if (gappy && $urandom_range(0, 5) == 0) begin
          pause_sender($urandom_range(1, 14));
        end
      end
    end

    // let the last results come out
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d inserts (%0d dropped when full), %0d pops (%0d empty)",
             n_requests, n_inserts, n_overflows, n_pops, n_empty_pops);
    $display("peak occupancy %0d of %0d, %0d mismatches", peak_occ, DEPTH, error_count);
    if (error_count == 0) begin
      $display("** priority_ordered_ready_queue: PASSED **");
    end else begin
      $display("** priority_ordered_ready_queue: FAILED **");
    end
    $finish;
  end

endmodule

// File: priority_ordered_ready_queue.f
src/prq_pkg.sv
src/prq_ram.sv
src/prq_datapath.sv
src/prq_ctrl.sv
src/priority_ordered_ready_queue.sv
verif/priority_ordered_ready_queue_tb.sv
